// ===== design/bae_pkg.sv =====
// Shared types and constants for the binary arithmetic encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package bae_pkg;

   // Operation codes carried on the request channel.
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Interval limits and the closing intervals used by a finish.
   localparam logic [31:0] MIN_LENGTH   = 32'h0100_0000;
   localparam logic [31:0] MAX_LENGTH   = 32'hFFFF_FFFF;
   localparam logic [31:0] TWICE_MIN    = 32'h0200_0000;
   localparam logic [31:0] HALF_MIN     = 32'h0080_0000;
   localparam logic [31:0] CLOSE_LENGTH = 32'h0000_8000;
   localparam logic [31:0] TWO_BYTE_LIM = 32'h0001_0000;

   localparam logic [7:0]  BYTE_ONES    = 8'hFF;

   // Width of the held 0xFF run counter.
   localparam int RUN_W = 6;

   // Slots of one release record, in stream order.
   localparam int SEG_NUM   = 4;
   localparam int SEG_IDX_W = 2;
   localparam int SEG_CARRY = 0;
   localparam int SEG_TAKE0 = 1;
   localparam int SEG_FLUSH = 3;

   // One segment: a head byte followed by count fill bytes (0xFF or 0x00).
   typedef struct packed {
      logic [7:0]       head;
      logic             fill_ones;
      logic [RUN_W-1:0] count;
   } seg_type;

   // Everything one item releases, handed from the front to the back.
   typedef struct packed {
      logic [SEG_NUM-1:0]  seg_valid;
      seg_type [SEG_NUM-1:0] seg;
      logic                overflow;
      logic                finish;
   } rec_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/bae_if.sv =====
// Handshake interfaces for the request and response channels.
// Depends on nothing; the request payload width follows PROB_BITS.
interface bae_req_if #(parameter int PROB_BITS = 13);
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic                 bit_value;
   logic [PROB_BITS-1:0] zero_prob;

   modport source (output valid, output operation, output bit_value, output zero_prob,
                   input ready);
   modport sink   (input valid, input operation, input bit_value, input zero_prob,
                   output ready);
endinterface

interface bae_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       stream_end;
   logic       run_overflow;

   modport source (output valid, output out_byte, output last, output stream_end,
                   output run_overflow, input ready);
   modport sink   (input valid, input out_byte, input last, input stream_end,
                   input run_overflow, output ready);
endinterface

// ===== design/bae_front.sv =====
// Front end: accepts items, runs the interval update and renormalization,
// and emits one release record for each item that releases bytes. Depends on bae_pkg and bae_req_if.
module bae_front #(
   parameter int PROB_BITS  = 13,
   parameter int MAX_FF_RUN = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   bae_req_if.sink               req_ch,
   input  bae_pkg::q_status_type q_status,
   output logic                  push_valid,
   output bae_pkg::rec_type      push_data
);

   localparam int LEN_HI_W = 32 - PROB_BITS;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [7:0]                held;
      logic                      valid;
      logic [bae_pkg::RUN_W-1:0] run;
   } hold_type;

   state_type                  state_ff;
   logic                       op_ff;
   logic                       bit_ff;
   logic [31:0]                x_ff;
   logic [31:0]                base_ff;
   logic [31:0]                length_ff;
   logic [7:0]                 held_ff;
   logic                       held_valid_ff;
   logic [bae_pkg::RUN_W-1:0]  run_ff;

   logic [PROB_BITS-1:0]       prob_w;
   logic [LEN_HI_W-1:0]        len_hi_w;
   logic [31:0]                x_in;
   logic [32:0]                sum_w;
   logic [31:0]                base_upd;
   logic [31:0]                length_upd;
   logic [31:0]                base_in;
   logic [31:0]                length_in;
   logic [1:0]                 nbytes_w;
   logic [7:0]                 byte_w;
   logic                       ovf_w;
   hold_type                   hold_w;
   bae_pkg::rec_type           rec_w;
   logic                       any_w;
   logic                       commit_w;

   // A probability of zero acts as the smallest nonzero probability.
   assign prob_w   = (req_ch.zero_prob == '0) ? PROB_BITS'(1) : req_ch.zero_prob;
   assign len_hi_w = length_ff[31:PROB_BITS];
   assign x_in     = 32'(prob_w) * 32'(len_hi_w);

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      sum_w      = {1'b0, base_ff};
      length_upd = x_ff;
      if (op_ff == bae_pkg::OP_ENCODE) begin
         if (bit_ff) begin
            sum_w      = {1'b0, base_ff} + {1'b0, x_ff};
            length_upd = length_ff - x_ff;
         end
      end else begin
         if (length_ff > bae_pkg::TWICE_MIN) begin
            sum_w      = {1'b0, base_ff} + {1'b0, bae_pkg::MIN_LENGTH};
            length_upd = bae_pkg::HALF_MIN;
         end else begin
            sum_w      = {1'b0, base_ff} + {1'b0, bae_pkg::HALF_MIN};
            length_upd = bae_pkg::CLOSE_LENGTH;
         end
      end
      base_upd = sum_w[31:0];

      hold_w = '{held: held_ff, valid: held_valid_ff, run: run_ff};
      rec_w  = '0;
      ovf_w  = 1'b0;
      byte_w = '0;

      // A carry out of the base ripples into the held byte and its run.
      if (sum_w[32] && hold_w.valid) begin
         if (hold_w.run != '0) begin
            rec_w.seg_valid[bae_pkg::SEG_CARRY]      = 1'b1;
            rec_w.seg[bae_pkg::SEG_CARRY].head      = hold_w.held + 8'd1;
            rec_w.seg[bae_pkg::SEG_CARRY].fill_ones = 1'b0;
            rec_w.seg[bae_pkg::SEG_CARRY].count     = hold_w.run - bae_pkg::RUN_W'(1);
            hold_w.held = '0;
            hold_w.run  = '0;
         end else begin
            hold_w.held = hold_w.held + 8'd1;
         end
      end

      if (length_upd < bae_pkg::TWO_BYTE_LIM) begin
         nbytes_w = 2'd2;
      end else if (length_upd < bae_pkg::MIN_LENGTH) begin
         nbytes_w = 2'd1;
      end else begin
         nbytes_w = 2'd0;
      end

      // Up to two bytes leave the top of the base.
      for (int i = 0; i < 2; i++) begin
         if (2'(i) < nbytes_w) begin
            byte_w = base_upd[31-8*i -: 8];
            if (!hold_w.valid) begin
               hold_w.held  = byte_w;
               hold_w.valid = 1'b1;
            end else if (byte_w == bae_pkg::BYTE_ONES &&
                         hold_w.run != bae_pkg::RUN_W'(MAX_FF_RUN)) begin
               hold_w.run = hold_w.run + bae_pkg::RUN_W'(1);
            end else begin
               rec_w.seg_valid[bae_pkg::SEG_TAKE0+i]      = 1'b1;
               rec_w.seg[bae_pkg::SEG_TAKE0+i].head      = hold_w.held;
               rec_w.seg[bae_pkg::SEG_TAKE0+i].fill_ones = 1'b1;
               rec_w.seg[bae_pkg::SEG_TAKE0+i].count     = hold_w.run;
               if (byte_w == bae_pkg::BYTE_ONES) begin
                  ovf_w = 1'b1;
               end
               hold_w.held = byte_w;
               hold_w.run  = '0;
            end
         end
      end

      case (nbytes_w)
         2'd1:    begin
            base_in   = {base_upd[23:0], 8'h00};
            length_in = {length_upd[23:0], 8'h00};
         end
         2'd2:    begin
            base_in   = {base_upd[15:0], 16'h0000};
            length_in = {length_upd[15:0], 16'h0000};
         end
         default: begin
            base_in   = base_upd;
            length_in = length_upd;
         end
      endcase

      // A finish releases whatever is still held.
      if (op_ff == bae_pkg::OP_FINISH && hold_w.valid) begin
         rec_w.seg_valid[bae_pkg::SEG_FLUSH]      = 1'b1;
         rec_w.seg[bae_pkg::SEG_FLUSH].head      = hold_w.held;
         rec_w.seg[bae_pkg::SEG_FLUSH].fill_ones = 1'b1;
         rec_w.seg[bae_pkg::SEG_FLUSH].count     = hold_w.run;
      end

      rec_w.overflow = ovf_w;
      rec_w.finish   = (op_ff == bae_pkg::OP_FINISH);
   end

   assign any_w      = |rec_w.seg_valid;
   assign commit_w   = (state_ff == S_EXEC) && (!any_w || !q_status.full);
   assign push_valid = (state_ff == S_EXEC) && any_w && !q_status.full;
   assign push_data  = rec_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= '0;
         length_ff     <= bae_pkg::MAX_LENGTH;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         run_ff        <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (commit_w) begin
                  state_ff <= S_IDLE;
                  if (op_ff == bae_pkg::OP_FINISH) begin
                     base_ff       <= '0;
                     length_ff     <= bae_pkg::MAX_LENGTH;
                     held_ff       <= '0;
                     held_valid_ff <= 1'b0;
                     run_ff        <= '0;
                  end else begin
                     base_ff       <= base_in;
                     length_ff     <= length_in;
                     held_ff       <= hold_w.held;
                     held_valid_ff <= hold_w.valid;
                     run_ff        <= hold_w.run;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (state_ff == S_IDLE && req_ch.valid) begin
         op_ff  <= req_ch.operation;
         bit_ff <= req_ch.bit_value;
         x_ff   <= x_in;
      end
   end

endmodule

// ===== design/bae_queue.sv =====
// Short record queue between the front and the back end.
// Depends on bae_pkg for the record and status types.
module bae_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bae_pkg::rec_type      push_data,
   input  logic                  pop,
   output bae_pkg::rec_type      pop_data,
   output bae_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bae_pkg::rec_type  store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/bae_back.sv =====
// Back end: expands release records into output bytes, one per cycle while the response
// channel is not stalled, behind a registered response stage. Depends on bae_pkg and bae_rsp_if.
module bae_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bae_pkg::q_status_type q_status,
   input  bae_pkg::rec_type      pop_data,
   output logic                  pop,
   bae_rsp_if.source             rsp_ch
);

   logic                                 busy_ff;
   logic [bae_pkg::SEG_NUM-1:0]          mask_ff;
   bae_pkg::seg_type [bae_pkg::SEG_NUM-1:0] segs_ff;
   logic                                 ovf_ff;
   logic                                 fin_ff;
   logic [bae_pkg::RUN_W-1:0]            pos_ff;
   logic                                 rsp_valid_ff;
   logic [7:0]                           byte_ff;
   logic                                 last_ff;
   logic                                 end_ff;
   logic                                 run_ovf_ff;

   logic [bae_pkg::SEG_IDX_W-1:0]        cur_idx;
   logic [bae_pkg::SEG_NUM-1:0]          cur_bit;
   logic [bae_pkg::SEG_NUM-1:0]          rest_mask;
   bae_pkg::seg_type                     cur_seg;
   logic [7:0]                           cur_byte;
   logic                                 seg_done;
   logic                                 item_last;
   logic                                 emit;

   // Lowest pending segment comes first in the stream.
   always_comb begin
      cur_idx = '0;
      for (int i = bae_pkg::SEG_NUM - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur_idx = bae_pkg::SEG_IDX_W'(i);
         end
      end
      cur_bit          = '0;
      cur_bit[cur_idx] = 1'b1;
   end

   assign rest_mask = mask_ff & ~cur_bit;
   assign cur_seg   = segs_ff[cur_idx];
   assign cur_byte  = (pos_ff == '0)   ? cur_seg.head :
                      cur_seg.fill_ones ? bae_pkg::BYTE_ONES : 8'h00;
   assign seg_done  = (pos_ff == cur_seg.count);
   assign item_last = seg_done && (rest_mask == '0);
   assign emit      = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign pop       = !busy_ff && !q_status.empty;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = byte_ff;
   assign rsp_ch.last         = last_ff;
   assign rsp_ch.stream_end   = end_ff;
   assign rsp_ch.run_overflow = run_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mask_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
            mask_ff <= pop_data.seg_valid;
            pos_ff  <= '0;
         end else if (emit) begin
            if (seg_done) begin
               mask_ff <= rest_mask;
               pos_ff  <= '0;
               if (item_last) begin
                  busy_ff <= 1'b0;
               end
            end else begin
               pos_ff <= pos_ff + bae_pkg::RUN_W'(1);
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         segs_ff <= pop_data.seg;
         ovf_ff  <= pop_data.overflow;
         fin_ff  <= pop_data.finish;
      end
      if (emit) begin
         byte_ff    <= cur_byte;
         last_ff    <= item_last;
         end_ff     <= item_last && fin_ff;
         run_ovf_ff <= ovf_ff;
      end
   end

endmodule

// ===== design/binary_arith_encoder_core.sv =====
// Top level of the binary arithmetic encoder: front end, record queue, back end.
// Depends on bae_pkg, bae_if, bae_front, bae_queue and bae_back.
//
//   Channel   Direction  Payload                                   Transfer when
//   req_ch    in         operation, bit_value, zero_prob           valid && ready
//   rsp_ch    out        out_byte, last, stream_end, run_overflow  valid && ready
//
// The front end takes a new item only while idle: the 13-by-19 interval multiply
// runs in the transfer cycle, and the exec state then updates the interval, applies any
// carry, renormalizes by up to two bytes and queues a release record if any bytes leave.
// The back end loads a record while idle and then sends one byte per cycle while rsp_ch
// is not stalled; it takes no new record until all n bytes of an item are sent (n is at most 51).
// Items that release no bytes never reach the back end.
// Reset is synchronous and restores the full interval, no held byte, and an
// empty queue; a finish item restores the same interval state once it is done.
// A stalled response fills the queue, and then the front end holds its item
// and stops taking requests until a slot frees up.
module binary_arith_encoder_core #(
   parameter int PROB_BITS   = 13,
   parameter int MAX_FF_RUN  = 48,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   bae_req_if.sink   req_ch,
   bae_rsp_if.source rsp_ch
);

   // Records flow from the front end through the queue to the back end.
   logic                  push_valid;
   bae_pkg::rec_type      push_data;
   logic                  pop;
   bae_pkg::rec_type      pop_data;
   bae_pkg::q_status_type q_status;

   bae_front #(
      .PROB_BITS  (PROB_BITS),
      .MAX_FF_RUN (MAX_FF_RUN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   bae_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   bae_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
